@@ sv/pcg4d_pkg.sv @@
// ----------------------------------------------------------------------------
// pcg4d_pkg
// Shared types, constants and control structs for the pcg4d hash generator.
// ----------------------------------------------------------------------------
package pcg4d_pkg;

   // Hash constants
   localparam logic [31:0] LCG_MUL  = 32'h0019660D;
   localparam logic [31:0] LCG_ADD  = 32'h3C6EF35F;
   localparam int unsigned XS_SHIFT = 16;

   // Twelve multiply-add steps per hash: four LCG, then two cross rounds
   localparam int unsigned NUM_STEPS = 12;
   localparam int unsigned STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
   // The xorshift is folded into the write-back of the last step of round one
   localparam logic [STEP_W-1:0] XS_STEP   = STEP_W'(7);
   localparam logic [STEP_W-1:0] CROSS_START = STEP_W'(4);

   // Operation codes
   typedef enum logic {
      OP_ADVANCE = 1'b0,
      OP_SEED    = 1'b1
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] seed_a;
      logic [31:0] seed_b;
      logic [31:0] seed_c;
      logic [31:0] seed_d;
   } req_type;

   typedef struct packed {
      logic [31:0] out_a;
      logic [31:0] out_b;
      logic [31:0] out_c;
      logic [31:0] out_d;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_FIN
   } ctrl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic              load;      // capture transaction, load seeds if seed op
      logic              mul;       // register the product for this step
      logic              add;       // write back addend + product
      logic              xorshift;  // apply xorshift to all words on write-back
      logic              rsp_load;  // copy words into the output register
      logic [STEP_W-1:0] step;
   } cmd_type;

endpackage

@@ sv/pcg4d_hash_generator_core.sv @@
// Each transaction runs twelve multiply-add steps on the single shared 32x32
// multiplier, each a registered product followed by the add and write-back (since
// every cross-round step depends on the one before), and then moves the words into
// the output register. The controller then returns to idle, so a new transaction is
// taken only once the previous hash is done. A new transaction is accepted while the
// previous result still waits in the output register; if that result is still waiting
// when the next hash is done, the hash holds and the input stays stalled until the
// output register frees up. The generator state resets to zero; an advance hashes the
// state, a seed hashes the supplied words, and either way the hashed vector becomes
// the new state and the result.
// ----------------------------------------------------------------------------
// pcg4d_hash_generator_core
// Top level of the pcg4d hash generator: controller plus datapath.
// ----------------------------------------------------------------------------
module pcg4d_hash_generator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pcg4d_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pcg4d_pkg::rsp_type  rsp_data
);

   pcg4d_pkg::cmd_type cmd;

   pcg4d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pcg4d_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Output register never overwritten while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before transfer");

   // Busy after accepting a transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a transaction while busy");

   // A fresh result only appears right after the output register load
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(cmd.rsp_load))
      else $error("result valid without a load");

endmodule

@@ sv/pcg4d_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcg4d_ctrl
// Sequencer for the pcg4d hash: steps the shared multiplier through the
// twelve multiply-add operations and manages the handshakes.
// ----------------------------------------------------------------------------
module pcg4d_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pcg4d_pkg::cmd_type  cmd
);

   pcg4d_pkg::ctrl_state_type      state_ff, state_in;
   logic [pcg4d_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcg4d_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.step     = step_ff;
      case (state_ff)
         pcg4d_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = pcg4d_pkg::ST_MUL;
            end
         end
         pcg4d_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pcg4d_pkg::ST_ADD;
         end
         pcg4d_pkg::ST_ADD: begin
            cmd.add      = 1'b1;
            cmd.xorshift = (step_ff == pcg4d_pkg::XS_STEP);
            if (step_ff == pcg4d_pkg::LAST_STEP) begin
               state_in = pcg4d_pkg::ST_FIN;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = pcg4d_pkg::ST_MUL;
            end
         end
         pcg4d_pkg::ST_FIN: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pcg4d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcg4d_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/pcg4d_dpath.sv @@
// ----------------------------------------------------------------------------
// pcg4d_dpath
// Generator state words, operand selection, shared 32x32 multiplier with
// registered product, adder and output register.
// ----------------------------------------------------------------------------
module pcg4d_dpath (
   input  logic                clock,
   input  logic                reset,
   input  pcg4d_pkg::cmd_type  cmd,
   input  pcg4d_pkg::req_type  req_data,
   output pcg4d_pkg::rsp_type  rsp_data
);

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] opa, opb, addend, sum;
   pcg4d_pkg::rsp_type rsp_ff;

   // Operand selection per step
   always_comb begin
      case (cmd.step) inside
         4'd0:           begin opa = a_ff; opb = pcg4d_pkg::LCG_MUL; end
         4'd1:           begin opa = b_ff; opb = pcg4d_pkg::LCG_MUL; end
         4'd2:           begin opa = c_ff; opb = pcg4d_pkg::LCG_MUL; end
         4'd3:           begin opa = d_ff; opb = pcg4d_pkg::LCG_MUL; end
         4'd4, 4'd8:     begin opa = b_ff; opb = d_ff; end
         4'd5, 4'd9:     begin opa = c_ff; opb = a_ff; end
         4'd6, 4'd10:    begin opa = a_ff; opb = b_ff; end
         4'd7, 4'd11:    begin opa = b_ff; opb = c_ff; end
         default:        begin opa = '0;   opb = '0;   end
      endcase
   end

   // Multiplier, low 32 bits kept
   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   // Addend: LCG constant in the first round, destination word afterwards
   always_comb begin
      if (cmd.step < pcg4d_pkg::CROSS_START) begin
         addend = pcg4d_pkg::LCG_ADD;
      end else begin
         case (cmd.step[1:0])
            2'd0:    addend = a_ff;
            2'd1:    addend = b_ff;
            2'd2:    addend = c_ff;
            2'd3:    addend = d_ff;
            default: addend = '0;
         endcase
      end
   end

   assign sum = addend + prod_ff;

   // Word update: load, write-back, optional xorshift of all words
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.load) begin
         if (req_data.operation == pcg4d_pkg::OP_SEED) begin
            a_in = req_data.seed_a;
            b_in = req_data.seed_b;
            c_in = req_data.seed_c;
            d_in = req_data.seed_d;
         end
      end else if (cmd.add) begin
         case (cmd.step[1:0])
            2'd0:    a_in = sum;
            2'd1:    b_in = sum;
            2'd2:    c_in = sum;
            2'd3:    d_in = sum;
            default: a_in = a_ff;
         endcase
         if (cmd.xorshift) begin
            a_in = a_in ^ (a_in >> pcg4d_pkg::XS_SHIFT);
            b_in = b_in ^ (b_in >> pcg4d_pkg::XS_SHIFT);
            c_in = c_in ^ (c_in >> pcg4d_pkg::XS_SHIFT);
            d_in = d_in ^ (d_in >> pcg4d_pkg::XS_SHIFT);
         end
      end
   end

   // Generator state, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.out_a <= a_ff;
         rsp_ff.out_b <= b_ff;
         rsp_ff.out_c <= c_ff;
         rsp_ff.out_d <= d_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ tb/pcg4d_hash_generator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcg4d_hash_generator_core_tb
// Self-checking testbench for the pcg4d hash generator. A queue-fed driver
// sends advance and seed transactions with random gaps, a monitor predicts
// each hashed vector from its own copy of the generator state and checks
// every result field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module pcg4d_hash_generator_core_tb;

   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned DRAIN_CYCLES = 40;

   // One pending transaction: payload, idle cycles before it, and whether
   // the sender first waits for all outstanding hashes
   typedef struct {
      pcg4d_pkg::req_type req;
      int unsigned        gap;
      bit                 drain;
   } hash_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   pcg4d_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   pcg4d_pkg::rsp_type rsp_data;

   hash_request_type   pending_requests[$];
   hash_request_type   next_request;
   pcg4d_pkg::rsp_type expected_hashes[$];
   pcg4d_pkg::rsp_type predicted_state = '0;
   pcg4d_pkg::rsp_type oldest_hash;
   string              word_names[4] = '{"out_a", "out_b", "out_c", "out_d"};

   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   int unsigned gap_count = 0;
   int unsigned stall_left = 0;
   bit          rx_no_stall = 1'b0;
   int unsigned results_taken = 0;
   int unsigned idle_cycles = 0;
   int unsigned error_count = 0;
   int unsigned advance_count = 0;
   int unsigned seed_count = 0;

   pcg4d_hash_generator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // pcg4d: LCG step, cross round, xorshift, cross round, all mod 2^32
   function automatic pcg4d_pkg::rsp_type pcg4d_mix(input pcg4d_pkg::rsp_type v);
      logic [31:0]        a, b, c, d;
      pcg4d_pkg::rsp_type r;
      a = v.out_a * pcg4d_pkg::LCG_MUL + pcg4d_pkg::LCG_ADD;
      b = v.out_b * pcg4d_pkg::LCG_MUL + pcg4d_pkg::LCG_ADD;
      c = v.out_c * pcg4d_pkg::LCG_MUL + pcg4d_pkg::LCG_ADD;
      d = v.out_d * pcg4d_pkg::LCG_MUL + pcg4d_pkg::LCG_ADD;
      for (int round = 0; round < 2; round++) begin
         a = a + b * d;
         b = b + c * a;
         c = c + a * b;
         d = d + b * c;
         if (round == 0) begin
            a = a ^ (a >> pcg4d_pkg::XS_SHIFT);
            b = b ^ (b >> pcg4d_pkg::XS_SHIFT);
            c = c ^ (c >> pcg4d_pkg::XS_SHIFT);
            d = d ^ (d >> pcg4d_pkg::XS_SHIFT);
         end
      end
      r.out_a = a;
      r.out_b = b;
      r.out_c = c;
      r.out_d = d;
      return r;
   endfunction

   // Random word biased toward the extremes
   function automatic logic [31:0] seed_word();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return 32'h0000_0000;
      end else if (pick == 1) begin
         return 32'hFFFF_FFFF;
      end
      return $urandom;
   endfunction

   task automatic queue_request(input pcg4d_pkg::op_type op, input logic [31:0] a,
                                input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d,
                                input int unsigned gap, input bit drain);
      hash_request_type item;
      item.req.operation = op;
      item.req.seed_a = a;
      item.req.seed_b = b;
      item.req.seed_c = c;
      item.req.seed_d = d;
      item.gap = gap;
      item.drain = drain;
      pending_requests.push_back(item);
   endtask

   // Driver: present the next transaction once the previous one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_requests[0].drain && expected_hashes.size() != 0) begin
            req_valid <= 1'b0;
         end else if (gap_count < pending_requests[0].gap) begin
            gap_count++;
            req_valid <= 1'b0;
         end else begin
            next_request = pending_requests.pop_front();
            req_data <= next_request.req;
            gap_count = 0;
            req_valid <= 1'b1;
         end
      end
   end

   // Receiver: random stall after each result unless in a no-stall stretch, two long hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            results_taken++;
            if (results_taken % 50 == 0) begin
               rx_no_stall = ($urandom_range(0, 3) == 0);
            end
            if (results_taken == 100 || results_taken == 900) begin
               stall_left = LONG_HOLD_CYCLES;
            end else if (rx_no_stall) begin
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 19);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hashes.size() == 0) begin
            $display("%0t: unexpected result %032h", $time, rsp_data);
            error_count++;
         end else begin
            oldest_hash = expected_hashes.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (oldest_hash[127 - 32 * i -: 32] !== rsp_data[127 - 32 * i -: 32]) begin
                  $display("%0t: %s mismatch: expected %08h, actual %08h", $time,
                           word_names[i], oldest_hash[127 - 32 * i -: 32],
                           rsp_data[127 - 32 * i -: 32]);
                  error_count++;
               end
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (req_data.operation == pcg4d_pkg::OP_SEED) begin
            predicted_state = pcg4d_mix({req_data.seed_a, req_data.seed_b,
                                         req_data.seed_c, req_data.seed_d});
            seed_count++;
         end else begin
            predicted_state = pcg4d_mix(predicted_state);
            advance_count++;
         end
         expected_hashes.push_back(predicted_state);
      end
      // Watchdog on cycles with no transaction on either channel
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d hashes outstanding", $time,
                  expected_hashes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int unsigned       random_sent;
      int unsigned       seg_len;
      bit                seg_burst;
      bit                drained;
      pcg4d_pkg::op_type op;

      random_sent = 0;
      drained = 1'b0;

      // Directed: advances from the zero state, ignored seed bits, seed extremes
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'hDEAD_BEEF, 32'h1234_5678, 32'h0,
                    32'hFFFF_FFFF, 3, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h5555_5555, 7, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h5555_5555, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'hAAAA_AAAA, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 19, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                    32'h0000_0001, 2, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 0,
                    1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1'b0);
      queue_request(pcg4d_pkg::OP_SEED, pcg4d_pkg::LCG_MUL, pcg4d_pkg::LCG_ADD,
                    pcg4d_pkg::LCG_MUL, pcg4d_pkg::LCG_ADD, 5, 1'b0);
      queue_request(pcg4d_pkg::OP_ADVANCE, 32'h0, 32'h0, 32'h0, 32'h0, 0, 1'b0);
      // Sender waits for every outstanding hash before the random part
      queue_request(pcg4d_pkg::OP_SEED, 32'h0000_FFFF, 32'hFFFF_0000, 32'h00FF_00FF,
                    32'hFF00_FF00, 0, 1'b1);

      // Random: segments of mostly advances, each opening with a seed half the time
      while (random_sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(4, 40);
         seg_burst = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < seg_len; k++) begin
            if ((k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 9) == 0) begin
               op = pcg4d_pkg::OP_SEED;
            end else begin
               op = pcg4d_pkg::OP_ADVANCE;
            end
            queue_request(op, seed_word(), seed_word(), seed_word(), seed_word(),
                          seg_burst ? 0 : $urandom_range(0, 19),
                          !drained && random_sent >= RANDOM_ITEMS / 2);
            if (random_sent >= RANDOM_ITEMS / 2) begin
               drained = 1'b1;
            end
            random_sent++;
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (pending_requests.size() == 0 && !req_valid);
      wait (expected_hashes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d advance and %0d seed transactions, %0d results checked,",
               advance_count, seed_count, results_taken);
      $display("with random gaps, stalls, two long receiver hold-offs and a sender drain.");
      if (error_count == 0 && expected_hashes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
